FILE: design/trrc_pkg.sv
package trrc_pkg;

    localparam int LETTERS = 26;
    localparam int ROTORS  = 3;

    typedef logic [4:0] letter_t;
    typedef logic [1:0] rotor_t;

    // Configuration register map
    typedef enum logic [2:0] {
        REG_SLOT0_ROTOR = 3'd0,
        REG_SLOT1_ROTOR = 3'd1,
        REG_SLOT2_ROTOR = 3'd2,
        REG_SLOT0_START = 3'd3,
        REG_SLOT1_START = 3'd4,
        REG_SLOT2_START = 3'd5
    } cfg_reg_t;

    localparam letter_t LAST_LETTER = letter_t'(LETTERS - 1);
    localparam rotor_t  LAST_ROTOR  = rotor_t'(ROTORS - 1);

    // Forward wirings, position -> letter
    localparam letter_t FWD_TBL [0:ROTORS-1][0:LETTERS-1] = '{
        '{5'd16, 5'd0,  5'd25, 5'd22, 5'd18, 5'd23, 5'd4,  5'd3,  5'd2,
          5'd17, 5'd5,  5'd21, 5'd19, 5'd6,  5'd1,  5'd24, 5'd7,  5'd13,
          5'd20, 5'd9,  5'd12, 5'd8,  5'd10, 5'd14, 5'd11, 5'd15},
        '{5'd16, 5'd22, 5'd4,  5'd17, 5'd19, 5'd24, 5'd20, 5'd8,  5'd14,
          5'd15, 5'd0,  5'd18, 5'd3,  5'd5,  5'd6,  5'd7,  5'd9,  5'd10,
          5'd11, 5'd25, 5'd23, 5'd2,  5'd21, 5'd1,  5'd13, 5'd12},
        '{5'd16, 5'd4,  5'd19, 5'd20, 5'd14, 5'd0,  5'd3,  5'd6,  5'd9,
          5'd11, 5'd25, 5'd2,  5'd1,  5'd12, 5'd22, 5'd17, 5'd24, 5'd8,
          5'd15, 5'd18, 5'd5,  5'd7,  5'd10, 5'd23, 5'd21, 5'd13}
    };

    // Inverse wirings, letter -> position
    localparam letter_t INV_TBL [0:ROTORS-1][0:LETTERS-1] = '{
        '{5'd1,  5'd14, 5'd8,  5'd7,  5'd6,  5'd10, 5'd13, 5'd16, 5'd21,
          5'd19, 5'd22, 5'd24, 5'd20, 5'd17, 5'd23, 5'd25, 5'd0,  5'd9,
          5'd4,  5'd12, 5'd18, 5'd11, 5'd3,  5'd5,  5'd15, 5'd2},
        '{5'd10, 5'd23, 5'd21, 5'd12, 5'd2,  5'd13, 5'd14, 5'd15, 5'd7,
          5'd16, 5'd17, 5'd18, 5'd25, 5'd24, 5'd8,  5'd9,  5'd0,  5'd3,
          5'd11, 5'd4,  5'd6,  5'd22, 5'd1,  5'd20, 5'd5,  5'd19},
        '{5'd5,  5'd12, 5'd11, 5'd6,  5'd1,  5'd20, 5'd7,  5'd21, 5'd17,
          5'd8,  5'd22, 5'd9,  5'd13, 5'd25, 5'd4,  5'd18, 5'd0,  5'd15,
          5'd19, 5'd2,  5'd3,  5'd24, 5'd14, 5'd23, 5'd16, 5'd10}
    };

    // Select code 3 falls back to the last wiring
    function automatic rotor_t rotor_pick(rotor_t sel);
        return (sel > LAST_ROTOR) ? LAST_ROTOR : sel;
    endfunction

    // Both operands below 26
    function automatic letter_t mod_add(letter_t a, letter_t b);
        logic [5:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= 6'(LETTERS)) begin
            sum = sum - 6'(LETTERS);
        end
        return sum[4:0];
    endfunction

    function automatic letter_t mod_inc(letter_t a);
        return (a == LAST_LETTER) ? 5'd0 : a + 5'd1;
    endfunction

    // Letters 26..31 wrap to 0..5
    function automatic letter_t letter_wrap(letter_t a);
        return (a > LAST_LETTER) ? a - letter_t'(LETTERS) : a;
    endfunction

    function automatic letter_t slot_fwd(rotor_t w, letter_t off, letter_t x);
        return FWD_TBL[w][mod_add(off, x)];
    endfunction

    function automatic letter_t slot_back(rotor_t w, letter_t off, letter_t y);
        letter_t p;
        p = INV_TBL[w][y];
        return (p >= off) ? p - off : p + letter_t'(LETTERS) - off;
    endfunction

    // Start letter outside the alphabet loads offset zero
    function automatic letter_t start_offset(rotor_t w, letter_t start);
        return (start > LAST_LETTER) ? 5'd0 : INV_TBL[w][start];
    endfunction

endpackage

FILE: design/three_rotor_reflector_cipher.sv
// Channel   Dir  Handshake              Payload
// s_        in   s_valid / s_ready      s_letter_in[4:0], s_message_start
// m_        out  m_valid / m_ready      m_letter_out[4:0]
// cfg_      in   cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[4:0]
//
// One item per cycle unless m_ready stalls; m_valid loads from a_valid_reg.
// Slot offsets and step counters advance at input accept, so the next item
// sees them at once; the rotor path runs between the input and result registers.
// aresetn (sync, active low) clears both stages, the offsets and counters, and
// loads the register defaults. A stalled m_ready holds the result register and
// s_ready stays high while the input register can move forward.
module three_rotor_reflector_cipher
    import trrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [4:0] s_letter_in,
    input  logic       s_message_start,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_letter_out,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [4:0] cfg_data
);

    // configuration
    rotor_t  slot0_rotor_reg, slot1_rotor_reg, slot2_rotor_reg;
    letter_t slot0_start_reg, slot1_start_reg, slot2_start_reg;

    // rotor state
    letter_t off_first_reg, off_second_reg, off_third_reg;
    letter_t steps_first_reg, steps_second_reg;
    letter_t off_first_next, off_second_next, off_third_next;
    letter_t steps_first_next, steps_second_next;

    // input stage: letter plus the offsets in force for it
    logic    a_valid_reg, a_valid_next;
    letter_t a_letter_reg;
    letter_t a_off0_reg, a_off1_reg, a_off2_reg;

    // result stage
    logic    m_valid_reg, m_valid_next;
    letter_t m_letter_reg;

    logic    s_accept, b_load;
    rotor_t  w0, w1, w2;
    letter_t eff0, eff1, eff2, eff_steps_first, eff_steps_second;
    letter_t fwd0, fwd1, fwd2, refl, bck2, bck1, bck0;

    assign w0 = rotor_pick(slot0_rotor_reg);
    assign w1 = rotor_pick(slot1_rotor_reg);
    assign w2 = rotor_pick(slot2_rotor_reg);

    // handshake
    assign b_load    = !m_valid_reg || m_ready;
    assign s_ready   = !a_valid_reg || b_load;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_letter_out = m_letter_reg;

    // config writes; out-of-map indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot0_rotor_reg <= 2'd0;
            slot1_rotor_reg <= 2'd1;
            slot2_rotor_reg <= 2'd2;
            slot0_start_reg <= 5'd0;
            slot1_start_reg <= 5'd0;
            slot2_start_reg <= 5'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SLOT0_ROTOR: slot0_rotor_reg <= cfg_data[1:0];
                REG_SLOT1_ROTOR: slot1_rotor_reg <= cfg_data[1:0];
                REG_SLOT2_ROTOR: slot2_rotor_reg <= cfg_data[1:0];
                REG_SLOT0_START: slot0_start_reg <= cfg_data;
                REG_SLOT1_START: slot1_start_reg <= cfg_data;
                REG_SLOT2_START: slot2_start_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // message start reloads offsets and clears counters for this item
    always_comb begin
        if (s_message_start) begin
            eff0             = start_offset(w0, slot0_start_reg);
            eff1             = start_offset(w1, slot1_start_reg);
            eff2             = start_offset(w2, slot2_start_reg);
            eff_steps_first  = 5'd0;
            eff_steps_second = 5'd0;
        end else begin
            eff0             = off_first_reg;
            eff1             = off_second_reg;
            eff2             = off_third_reg;
            eff_steps_first  = steps_first_reg;
            eff_steps_second = steps_second_reg;
        end
    end

    // odometer stepping after the letter
    always_comb begin
        off_first_next    = mod_inc(eff0);
        off_second_next   = eff1;
        off_third_next    = eff2;
        steps_first_next  = eff_steps_first + 5'd1;
        steps_second_next = eff_steps_second;
        if (eff_steps_first == LAST_LETTER) begin
            steps_first_next  = 5'd0;
            off_second_next   = mod_inc(eff1);
            steps_second_next = eff_steps_second + 5'd1;
            if (eff_steps_second == LAST_LETTER) begin
                steps_second_next = 5'd0;
                off_third_next    = mod_inc(eff2);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_first_reg    <= 5'd0;
            off_second_reg   <= 5'd0;
            off_third_reg    <= 5'd0;
            steps_first_reg  <= 5'd0;
            steps_second_reg <= 5'd0;
        end else if (s_accept) begin
            off_first_reg    <= off_first_next;
            off_second_reg   <= off_second_next;
            off_third_reg    <= off_third_next;
            steps_first_reg  <= steps_first_next;
            steps_second_reg <= steps_second_next;
        end
    end

    // input stage
    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_accept) begin
            a_valid_next = 1'b1;
        end else if (b_load) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_letter_reg <= letter_wrap(s_letter_in);
            a_off0_reg   <= eff0;
            a_off1_reg   <= eff1;
            a_off2_reg   <= eff2;
        end
    end

    // rotor path: forward through three slots, reflect, back through inverses
    assign fwd0 = slot_fwd(w0, a_off0_reg, a_letter_reg);
    assign fwd1 = slot_fwd(w1, a_off1_reg, fwd0);
    assign fwd2 = slot_fwd(w2, a_off2_reg, fwd1);
    assign refl = LAST_LETTER - fwd2;
    assign bck2 = slot_back(w2, a_off2_reg, refl);
    assign bck1 = slot_back(w1, a_off1_reg, bck2);
    assign bck0 = slot_back(w0, a_off0_reg, bck1);

    // result stage
    always_comb begin
        m_valid_next = m_valid_reg;
        if (b_load) begin
            m_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_load && a_valid_reg) begin
            m_letter_reg <= bck0;
        end
    end

endmodule

FILE: sim/three_rotor_reflector_cipher_test.sv
`timescale 1ns / 1ps

module three_rotor_reflector_cipher_test;
    import trrc_pkg::*;

    // Indexes outside the register map; writes there must change nothing
    localparam logic [2:0] REG_SPARE6 = 3'd6;
    localparam logic [2:0] REG_SPARE7 = 3'd7;

    localparam int CODE_A      = 65;      // ASCII 'A'
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 100;     // mismatch lines shown before going quiet
    localparam int LONG_MSG    = 100;     // several carries into the second slot
    localparam int PHASE_ITEMS = 40;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [4:0] s_letter_in;
    logic       s_message_start;
    logic       m_valid;
    logic       m_ready;
    logic [4:0] m_letter_out;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [4:0] cfg_data;

    three_rotor_reflector_cipher u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_letter_in     (s_letter_in),
        .s_message_start (s_message_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_letter_out    (m_letter_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------
    // Cipher predictor: wiring tables, shadow registers, rotor state
    // ------------------------------------------------------------------
    string rotor_text [3] = '{
        "QAZWSXEDCRFVTGBYHNUJMIKOLP",
        "QWERTYUIOPASDFGHJKLZXCVBNM",
        "QETUOADGJLZCBMWRYIPSFHKXVN"
    };
    int wire_map [3][26];        // position -> letter, per wiring

    logic [1:0] slot_rotor [3];  // shadow of the rotor select registers
    logic [4:0] slot_start [3];  // shadow of the start letter registers
    int         slot_off   [3];
    int         first_steps;
    int         second_steps;

    letter_t pending_letters [$]; // expected m_letter_out, oldest first

    int  fail_count;
    int  cycle_count;
    int  items_sent;
    int  results_seen;
    int  reg_writes;
    int  messages;
    int  run_len;
    int  longest_run;
    bit  no_idle;                 // set for whole phases: back-to-back traffic

    function automatic int wiring_for(logic [1:0] sel);
        // select 3 saturates to the last wiring
        return (sel > 2'd2) ? 2 : int'(sel);
    endfunction

    // Position of letter c in wiring w; letters outside the alphabet give 0
    function automatic int wire_pos(int w, int c);
        for (int k = 0; k < LETTERS; k++) begin
            if (wire_map[w][k] == c) begin
                return k;
            end
        end
        return 0;
    endfunction

    function automatic void predictor_reset();
        for (int s = 0; s < 3; s++) begin
            slot_rotor[s] = 2'(s);
            slot_start[s] = '0;
            slot_off[s]   = 0;
        end
        first_steps  = 0;
        second_steps = 0;
    endfunction

    function automatic void shadow_write(logic [2:0] idx, logic [4:0] data);
        case (idx)
            REG_SLOT0_ROTOR: slot_rotor[0] = data[1:0];
            REG_SLOT1_ROTOR: slot_rotor[1] = data[1:0];
            REG_SLOT2_ROTOR: slot_rotor[2] = data[1:0];
            REG_SLOT0_START: slot_start[0] = data;
            REG_SLOT1_START: slot_start[1] = data;
            REG_SLOT2_START: slot_start[2] = data;
            default: ;
        endcase
    endfunction

    // Transform one letter and step the rotors, odometer style
    function automatic letter_t cipher_letter(logic [4:0] raw, logic restart);
        int w [3];
        int x;
        for (int s = 0; s < 3; s++) begin
            w[s] = wiring_for(slot_rotor[s]);
        end
        x = int'(raw) % LETTERS;              // 26..31 fold onto 0..5
        if (restart) begin
            for (int s = 0; s < 3; s++) begin
                slot_off[s] = wire_pos(w[s], int'(slot_start[s]));
            end
            first_steps  = 0;
            second_steps = 0;
        end
        for (int s = 0; s < 3; s++) begin
            x = wire_map[w[s]][(slot_off[s] + x) % LETTERS];
        end
        x = (LETTERS - 1) - x;                // reverse-alphabet reflector
        for (int s = 2; s >= 0; s--) begin
            x = (wire_pos(w[s], x) + LETTERS - slot_off[s]) % LETTERS;
        end
        slot_off[0] = (slot_off[0] + 1) % LETTERS;
        first_steps++;
        if (first_steps >= LETTERS) begin
            first_steps = 0;
            slot_off[1] = (slot_off[1] + 1) % LETTERS;
            second_steps++;
            if (second_steps >= LETTERS) begin
                second_steps = 0;
                slot_off[2] = (slot_off[2] + 1) % LETTERS;
            end
        end
        return letter_t'(x);
    endfunction

    // Gap length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [2:0] reg_idx;     // register rows only
        logic [4:0] value;       // letter for item rows, data for register rows
        logic       restart;     // message_start for item rows
        bit         typed;       // result given below instead of predicted
        letter_t    want;
    } row_t;

    localparam int PLAN_ROWS = 25;

    row_t plan [PLAN_ROWS] = '{
        // straight out of reset: defaults 0/1/2, all offsets zero, A -> I
        '{ROW_ITEM, '0,              5'd0,  1'b0, 1'b1, 5'd8},
        '{ROW_ITEM, '0,              5'd25, 1'b0, 1'b0, '0},
        '{ROW_ITEM, '0,              5'd31, 1'b0, 1'b0, '0},   // wraps to F
        '{ROW_ITEM, '0,              5'd26, 1'b1, 1'b0, '0},   // reload, wraps to A
        '{ROW_ITEM, '0,              5'd13, 1'b0, 1'b0, '0},
        // saturating select, shared wiring, masked select, bad start letters
        '{ROW_REG,  REG_SLOT0_ROTOR, 5'd3,  1'b0, 1'b0, '0},
        '{ROW_REG,  REG_SLOT1_ROTOR, 5'd2,  1'b0, 1'b0, '0},
        '{ROW_REG,  REG_SLOT2_ROTOR, 5'd28, 1'b0, 1'b0, '0},
        '{ROW_REG,  REG_SLOT0_START, 5'd25, 1'b0, 1'b0, '0},
        '{ROW_REG,  REG_SLOT1_START, 5'd31, 1'b0, 1'b0, '0},
        '{ROW_REG,  REG_SLOT2_START, 5'd26, 1'b0, 1'b0, '0},
        '{ROW_REG,  REG_SPARE6,      5'd31, 1'b0, 1'b0, '0},
        '{ROW_REG,  REG_SPARE7,      5'd0,  1'b0, 1'b0, '0},
        '{ROW_ITEM, '0,              5'd0,  1'b1, 1'b0, '0},
        '{ROW_ITEM, '0,              5'd25, 1'b0, 1'b0, '0},
        '{ROW_ITEM, '0,              5'd31, 1'b0, 1'b0, '0},
        '{ROW_ITEM, '0,              5'd7,  1'b1, 1'b0, '0},
        // same wiring in every slot
        '{ROW_REG,  REG_SLOT0_ROTOR, 5'd1,  1'b0, 1'b0, '0},
        '{ROW_REG,  REG_SLOT1_ROTOR, 5'd1,  1'b0, 1'b0, '0},
        '{ROW_REG,  REG_SLOT2_ROTOR, 5'd1,  1'b0, 1'b0, '0},
        '{ROW_REG,  REG_SLOT0_START, 5'd0,  1'b0, 1'b0, '0},
        '{ROW_ITEM, '0,              5'd25, 1'b1, 1'b0, '0},
        '{ROW_ITEM, '0,              5'd0,  1'b0, 1'b0, '0},
        '{ROW_ITEM, '0,              5'd18, 1'b1, 1'b0, '0},
        '{ROW_ITEM, '0,              5'd30, 1'b0, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results still owed",
                 $time, cycle_count, pending_letters.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers: everything changes on the falling edge
    // ------------------------------------------------------------------

    // Offer one letter, wait for acceptance, log its expected result
    task automatic push_letter(logic [4:0] letter, logic restart, bit typed, letter_t want);
        int      gap;
        letter_t guess;
        gap = idle_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_letter_in     = letter;
        s_message_start = restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // accepted at this edge; state steps here in the block too
        guess = cipher_letter(letter, restart);
        pending_letters.push_back(typed ? want : guess);
        items_sent++;
        if (restart) begin
            messages++;
            run_len = 0;
        end
        run_len++;
        if (run_len > longest_run) begin
            longest_run = run_len;
        end
    endtask

    // Quiet the input and let the pipe empty before touching registers
    task automatic settle_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_letters.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);           // two-stage pipe plus margin
    endtask

    task automatic write_reg(logic [2:0] idx, logic [4:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        shadow_write(idx, data);
        reg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Result side back-pressure: random stalls, then runs of ready
    initial begin : result_pacer
        int hold;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            hold = idle_len();
            if (hold > 0) begin
                m_ready = 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: sampled on the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        letter_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_letters.size() == 0) begin
                fail_count++;
                if (fail_count <= PRINT_CAP) begin
                    $display("%0t: letter_out expected nothing, actual %0d",
                             $time, m_letter_out);
                end
            end else begin
                want = pending_letters.pop_front();
                if (m_letter_out !== want) begin
                    fail_count++;
                    if (fail_count <= PRINT_CAP) begin
                        $display("%0t: letter_out expected %0d, actual %0d",
                                 $time, want, m_letter_out);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int         budget;
        int         sent;
        int         len;
        logic [4:0] letter;
        logic [4:0] data;
        logic       restart;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_letter_in     = '0;
        s_message_start = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        fail_count      = 0;
        items_sent      = 0;
        results_seen    = 0;
        reg_writes      = 0;
        messages        = 0;
        run_len         = 0;
        longest_run     = 0;
        no_idle         = 1'b0;

        for (int w = 0; w < 3; w++) begin
            for (int p = 0; p < LETTERS; p++) begin
                wire_map[w][p] = int'(rotor_text[w][p]) - CODE_A;
            end
        end
        predictor_reset();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part; register rows only go in once the pipe is empty
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                settle_idle();
                write_reg(plan[i].reg_idx, plan[i].value);
            end else begin
                push_letter(plan[i].value, plan[i].restart, plan[i].typed, plan[i].want);
            end
        end

        // Random part: phases of fresh settings, each a string of messages.
        // Phase 0 loads every field at its top, phase 1 at zero; phase 5 is a
        // single long message that carries into the second slot several times.
        for (int phase = 0; phase < 8; phase++) begin
            no_idle = (phase % 3 == 2);
            settle_idle();
            for (int r = REG_SLOT0_ROTOR; r <= REG_SLOT2_START; r++) begin
                if (phase == 0) begin
                    data = (r <= REG_SLOT2_ROTOR) ? 5'd31 : 5'd25;
                end else if (phase == 1) begin
                    data = '0;
                end else if (r <= REG_SLOT2_ROTOR || $urandom_range(0, 6) != 0) begin
                    data = (r <= REG_SLOT2_ROTOR) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(0, 25));
                end else begin
                    data = 5'($urandom_range(26, 31));
                end
                write_reg(cfg_reg_t'(r), data);
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7,
                          5'($urandom_range(0, 31)));
            end

            budget = (phase == 5) ? LONG_MSG : PHASE_ITEMS;
            sent   = 0;
            while (sent < budget) begin
                len = (phase == 5) ? budget : $urandom_range(1, 40);
                if (len > budget - sent) begin
                    len = budget - sent;
                end
                for (int k = 0; k < len; k++) begin
                    letter = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
                                                         : 5'($urandom_range(0, 25));
                    if (k == 0) begin
                        // now and then carry rotor state across a settings change
                        restart = (phase == 5) || ($urandom_range(0, 9) != 0);
                    end else begin
                        restart = (phase != 5) && ($urandom_range(0, 49) == 0);
                    end
                    push_letter(letter, restart, 1'b0, '0);
                    sent++;
                end
            end
        end

        settle_idle();
        repeat (8) @(posedge aclk);           // catch any stray result

        $display("Covered %0d letters in %0d messages under %0d register writes.",
                 items_sent, messages, reg_writes);
        $display("Checked %0d results; longest unbroken message %0d letters.",
                 results_seen, longest_run);
        if (fail_count == 0 && pending_letters.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
